/* rtl/ajpc_pkg.sv */
// Shared types and constants for the arm joint position controller.
// Used by ajpc_core and arm_joint_position_controller_top; no dependencies.
`default_nettype none

package ajpc_pkg;

  localparam int unsigned SAMPLE_BITS = 10;
  localparam int unsigned GLITCH_BITS = 4;
  localparam int unsigned REQ_BITS    = 3;
  localparam int unsigned CFG_IDX_BITS = 3;

  typedef logic [SAMPLE_BITS-1:0] pos_t;
  typedef logic [GLITCH_BITS-1:0] glitch_t;

  // Register reset values
  localparam pos_t    MinPosRst    = '0;
  localparam pos_t    MaxPosRst    = SAMPLE_BITS'(1023);
  localparam pos_t    ParkPosRst   = SAMPLE_BITS'(512);
  localparam glitch_t GlitchLimRst = GLITCH_BITS'(5);
  localparam pos_t    GlitchJmpRst = SAMPLE_BITS'(100);
  localparam pos_t    DeadbandRst  = SAMPLE_BITS'(10);

  typedef enum logic [REQ_BITS-1:0] {
    REQ_TICK    = 3'd0,
    REQ_MOVE_TO = 3'd1,
    REQ_MOVE_DIR = 3'd2,
    REQ_RELEASE = 3'd3,
    REQ_BRAKE   = 3'd4,
    REQ_PARK    = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    DIR_FWD = 2'd0,
    DIR_BWD = 2'd1,
    DIR_REL = 2'd2,
    DIR_BRK = 2'd3
  } dir_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MIN_POS    = 3'd0,
    CFG_MAX_POS    = 3'd1,
    CFG_PARK_POS   = 3'd2,
    CFG_GLITCH_LIM = 3'd3,
    CFG_GLITCH_JMP = 3'd4,
    CFG_DEADBAND   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [REQ_BITS-1:0] req_type;
    pos_t                sensor_sample;
    pos_t                goal_position;
    logic                move_backward;
  } in_t;

  typedef struct packed {
    logic [1:0] drive_dir;
    logic       drive_changed;
    logic       move_done;
    logic       fault_code;
    pos_t       target_out;
    pos_t       distance_out;
  } out_t;

  typedef struct packed {
    pos_t    min_position;
    pos_t    max_position;
    pos_t    park_position;
    glitch_t glitch_limit;
    pos_t    glitch_jump;
    pos_t    deadband;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/ajpc_core.sv */
// Joint control state and the per-transaction update logic.
// Depends on ajpc_pkg for the request, result and register types.
`default_nettype none

module ajpc_core import ajpc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic step_i,
  input  wire in_t  req_i,
  input  wire cfg_t cfg_i,
  output out_t      res_o
);

  pos_t    target_q, target_d;
  pos_t    last_q, last_d;
  dir_e    dir_q, dir_d;
  glitch_t glitch_q, glitch_d;
  logic    done_q, done_d;
  logic    fault_q, fault_d;
  pos_t    dist_q, dist_d;
  logic    changed;

  function automatic pos_t clamp_pos(pos_t p, pos_t lo, pos_t hi);
    if (p < lo) begin
      return lo;
    end else if (p > hi) begin
      return hi;
    end
    return p;
  endfunction

  function automatic pos_t abs_diff(pos_t a, pos_t b);
    return (a > b) ? a - b : b - a;
  endfunction

  pos_t sample;
  pos_t jump;
  pos_t dist_new;
  dir_e want;
  logic want_drive;

  assign sample   = req_i.sensor_sample;
  assign jump     = abs_diff(last_q, sample);
  assign dist_new = abs_diff(target_q, sample);

  always_comb begin
    target_d   = target_q;
    last_d     = last_q;
    dir_d      = dir_q;
    glitch_d   = glitch_q;
    done_d     = done_q;
    fault_d    = fault_q;
    dist_d     = dist_q;
    want       = DIR_REL;
    want_drive = 1'b0;

    case (req_i.req_type)
      REQ_TICK: begin
        if (dir_q == DIR_BRK) begin
          // braked: ignore ticks
        end else if (glitch_q >= cfg_i.glitch_limit) begin
          // noise brake: release, then hold in brake with the fault set
          want_drive = 1'b1;
          want       = DIR_REL;
          target_d   = clamp_pos(sample, cfg_i.min_position, cfg_i.max_position);
          done_d     = 1'b1;
          fault_d    = 1'b1;
          glitch_d   = '0;
        end else if (jump >= cfg_i.glitch_jump) begin
          if (glitch_q != '1) begin
            glitch_d = glitch_q + GLITCH_BITS'(1);
          end
        end else begin
          dist_d = dist_new;
          last_d = sample;
          if (sample < cfg_i.min_position) begin
            want_drive = 1'b1;
            want       = DIR_FWD;
          end else if (sample > cfg_i.max_position) begin
            want_drive = 1'b1;
            want       = DIR_BWD;
          end else if (dist_new < cfg_i.deadband) begin
            want_drive = 1'b1;
            want       = DIR_REL;
            done_d     = 1'b1;
          end else if (sample < target_q) begin
            want_drive = 1'b1;
            want       = DIR_FWD;
          end else if (sample > target_q) begin
            want_drive = 1'b1;
            want       = DIR_BWD;
          end
        end
      end
      REQ_MOVE_TO: begin
        target_d   = clamp_pos(req_i.goal_position, cfg_i.min_position, cfg_i.max_position);
        done_d     = 1'b0;
        want_drive = 1'b1;
        want       = DIR_REL;
      end
      REQ_MOVE_DIR: begin
        want_drive = 1'b1;
        done_d     = 1'b0;
        if (req_i.move_backward) begin
          target_d = cfg_i.min_position;
          want     = DIR_BWD;
        end else begin
          target_d = cfg_i.max_position;
          want     = DIR_FWD;
        end
      end
      REQ_RELEASE, REQ_BRAKE: begin
        want_drive = 1'b1;
        want       = DIR_REL;
        target_d   = clamp_pos(sample, cfg_i.min_position, cfg_i.max_position);
        done_d     = 1'b1;
      end
      REQ_PARK: begin
        target_d   = clamp_pos(cfg_i.park_position, cfg_i.min_position, cfg_i.max_position);
        done_d     = 1'b0;
        want_drive = 1'b1;
        want       = DIR_REL;
      end
      default: begin
        // unused request codes leave the state alone
      end
    endcase

    changed = want_drive && (want != dir_q);
    if (want_drive) begin
      dir_d = want;
    end
    // brake overrides the release direction without a run command
    if (req_i.req_type == REQ_BRAKE ||
        (req_i.req_type == REQ_TICK && dir_q != DIR_BRK &&
         glitch_q >= cfg_i.glitch_limit)) begin
      dir_d = DIR_BRK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= MinPosRst;
      last_q   <= MinPosRst;
      dir_q    <= DIR_BRK;
      glitch_q <= '0;
      done_q   <= 1'b1;
      fault_q  <= 1'b0;
      dist_q   <= '0;
    end else if (step_i) begin
      target_q <= target_d;
      last_q   <= last_d;
      dir_q    <= dir_d;
      glitch_q <= glitch_d;
      done_q   <= done_d;
      fault_q  <= fault_d;
      dist_q   <= dist_d;
    end
  end

  always_comb begin
    res_o.drive_dir     = dir_d;
    res_o.drive_changed = changed;
    res_o.move_done     = done_d;
    res_o.fault_code    = fault_d;
    res_o.target_out    = target_d;
    res_o.distance_out  = dist_d;
  end

  // Noise fault never clears once set
  assert property (@(posedge clk_i) disable iff (!rst_ni) fault_q |=> fault_q)
    else $error("noise fault cleared");

  // A fresh noise fault always leaves the joint braked with no glitches pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      $rose(fault_q) |-> (dir_q == DIR_BRK && glitch_q == '0))
    else $error("noise fault without brake");

  // A run command outside a brake request means the direction really moved
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (step_i && res_o.drive_changed && req_i.req_type != REQ_BRAKE)
      |=> (dir_q != $past(dir_q)))
    else $error("run command without direction change");

  // State holds between transactions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      !step_i |=> ($stable(target_q) && $stable(dir_q) && $stable(glitch_q)))
    else $error("state moved without a transaction");

endmodule

`default_nettype wire

/* rtl/arm_joint_position_controller_top.sv */
// Top level of the arm joint position controller: handshakes, register file,
// input and result registers. Depends on ajpc_pkg and ajpc_core.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------
//   in      | input     | in_valid_i/in_stall_o   | in_data_i (in_t)
//   out     | output    | out_valid_o/out_stall_i | out_data_o (out_t)
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One transaction per cycle sustained while out_stall_i stays low; an accepted
// transaction passes through the input register, then the result register.
// The state update sits between the input register and the result register.
// Reset returns the limits to their defaults and the joint to braked, done.
// A stalled result holds in place; the input register keeps filling until
// it too is occupied, and only then is in_stall_o raised.
`default_nettype none

module arm_joint_position_controller_top import ajpc_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire in_t                     in_data_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output out_t                         out_data_o,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  wire logic [SAMPLE_BITS-1:0]  cfg_data_i
);

  cfg_t cfg_q, cfg_d;
  logic s1_valid_q, s1_valid_d;
  in_t  s1_q;
  logic out_valid_q, out_valid_d;
  out_t out_q;
  out_t res;
  logic out_ready;
  logic step;
  logic in_acc;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MIN_POS:    cfg_d.min_position  = cfg_data_i;
        CFG_MAX_POS:    cfg_d.max_position  = cfg_data_i;
        CFG_PARK_POS:   cfg_d.park_position = cfg_data_i;
        CFG_GLITCH_LIM: cfg_d.glitch_limit  = cfg_data_i[GLITCH_BITS-1:0];
        CFG_GLITCH_JMP: cfg_d.glitch_jump   = cfg_data_i;
        CFG_DEADBAND:   cfg_d.deadband      = cfg_data_i;
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign step       = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (step) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_position  <= MinPosRst;
      cfg_q.max_position  <= MaxPosRst;
      cfg_q.park_position <= ParkPosRst;
      cfg_q.glitch_limit  <= GlitchLimRst;
      cfg_q.glitch_jump   <= GlitchJmpRst;
      cfg_q.deadband      <= DeadbandRst;
      s1_valid_q          <= 1'b0;
      out_valid_q         <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= in_data_i;
    end
    if (step) begin
      out_q <= res;
    end
  end

  ajpc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .req_i  (s1_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* bench/tb_arm_joint_position_controller_top.sv */
// Self-checking bench for arm_joint_position_controller_top: directed table, then random phases.
// Uses ajpc_pkg types; predicts each result with an in-bench model of the joint controller.
// Both sides idle and stall at random; the receiver also holds off once to back-pressure the input.
module tb_arm_joint_position_controller_top;
  import ajpc_pkg::*;

  localparam int CLK_HALF        = 5;
  localparam int RESET_CYCLES    = 12;
  localparam int IDLE_PCT        = 20;
  localparam int HOLD_CYCLES     = 60;
  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int RAND_PHASES     = 6;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int QUIET_PHASE     = 4;
  localparam int HOLD_PHASE      = 1;

  // Request codes the block must ignore
  localparam logic [REQ_BITS-1:0] REQ_SPARE_LO = 3'd6;
  localparam logic [REQ_BITS-1:0] REQ_SPARE_HI = 3'd7;

  localparam out_t NO_WANT = '0;

  typedef struct packed {
    in_t  stim;
    logic fixed;
    out_t want;
  } row_t;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_stall_o;
  in_t                     in_data_i   = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  out_t                    out_data_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i = CFG_MIN_POS;
  logic [SAMPLE_BITS-1:0]  cfg_data_i  = '0;

  arm_joint_position_controller_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Joint model state
  cfg_t     joint_cfg;
  pos_t     jt_target;
  pos_t     jt_last_good;
  dir_e     jt_dir;
  glitch_t  jt_glitches;
  logic     jt_done;
  logic     jt_fault;
  pos_t     jt_dist;
  logic     jt_run_cmd;

  out_t pending_results [$];
  out_t oldest;
  int   mismatches = 0;
  bit   quiet      = 1'b0;
  int   hold_seq   = 0;
  int   hold_seen  = 0;
  int   hold_left  = 0;

  row_t plan [23] = '{
    '{'{REQ_TICK, 10'd500, 10'd0, 1'b0}, 1'b1,
      '{DIR_BRK, 1'b0, 1'b1, 1'b0, 10'd0, 10'd0}},
    '{'{REQ_SPARE_LO, 10'd1023, 10'd1023, 1'b1}, 1'b1,
      '{DIR_BRK, 1'b0, 1'b1, 1'b0, 10'd0, 10'd0}},
    '{'{REQ_SPARE_HI, 10'd0, 10'd0, 1'b0}, 1'b1,
      '{DIR_BRK, 1'b0, 1'b1, 1'b0, 10'd0, 10'd0}},
    '{'{REQ_MOVE_TO, 10'd0, 10'd1023, 1'b0}, 1'b1,
      '{DIR_REL, 1'b1, 1'b0, 1'b0, 10'd1023, 10'd0}},
    '{'{REQ_TICK, 10'd0, 10'd0, 1'b0}, 1'b1,
      '{DIR_FWD, 1'b1, 1'b0, 1'b0, 10'd1023, 10'd1023}},
    '{'{REQ_TICK, 10'd99, 10'd0, 1'b0}, 1'b0, NO_WANT},
    '{'{REQ_TICK, 10'd199, 10'd0, 1'b0}, 1'b0, NO_WANT},
    '{'{REQ_TICK, 10'd1023, 10'd0, 1'b0}, 1'b0, NO_WANT},
    '{'{REQ_TICK, 10'd1023, 10'd0, 1'b0}, 1'b0, NO_WANT},
    '{'{REQ_TICK, 10'd1023, 10'd0, 1'b0}, 1'b0, NO_WANT},
    '{'{REQ_TICK, 10'd1023, 10'd0, 1'b0}, 1'b0, NO_WANT},
    // glitch count at the limit: noise brake with sticky fault
    '{'{REQ_TICK, 10'd700, 10'd0, 1'b0}, 1'b1,
      '{DIR_BRK, 1'b1, 1'b1, 1'b1, 10'd700, 10'd924}},
    '{'{REQ_RELEASE, 10'd1023, 10'd0, 1'b0}, 1'b0, NO_WANT},
    '{'{REQ_MOVE_DIR, 10'd0, 10'd0, 1'b1}, 1'b0, NO_WANT},
    '{'{REQ_MOVE_DIR, 10'd0, 10'd0, 1'b0}, 1'b0, NO_WANT},
    '{'{REQ_PARK, 10'd0, 10'd0, 1'b0}, 1'b0, NO_WANT},
    '{'{REQ_TICK, 10'd150, 10'd0, 1'b0}, 1'b0, NO_WANT},
    '{'{REQ_TICK, 10'd245, 10'd0, 1'b0}, 1'b0, NO_WANT},
    '{'{REQ_TICK, 10'd340, 10'd0, 1'b0}, 1'b0, NO_WANT},
    '{'{REQ_TICK, 10'd435, 10'd0, 1'b0}, 1'b0, NO_WANT},
    '{'{REQ_TICK, 10'd503, 10'd0, 1'b0}, 1'b0, NO_WANT},
    '{'{REQ_TICK, 10'd600, 10'd0, 1'b0}, 1'b0, NO_WANT},
    '{'{REQ_BRAKE, 10'd5, 10'd0, 1'b0}, 1'b0, NO_WANT}
  };

  // Min test wins when the limits cross
  function automatic pos_t clamp_to_limits(pos_t p);
    if (p < joint_cfg.min_position) return joint_cfg.min_position;
    if (p > joint_cfg.max_position) return joint_cfg.max_position;
    return p;
  endfunction

  function automatic void steer(dir_e d);
    if (jt_dir != d) begin
      jt_dir     = d;
      jt_run_cmd = 1'b1;
    end
  endfunction

  function automatic void hold_still(pos_t sample);
    steer(DIR_REL);
    jt_target = clamp_to_limits(sample);
    jt_done   = 1'b1;
  endfunction

  function automatic void head_for(pos_t goal);
    jt_target = clamp_to_limits(goal);
    jt_done   = 1'b0;
    steer(DIR_REL);
  endfunction

  function automatic out_t step_joint(in_t t);
    pos_t jump;
    out_t res;
    jt_run_cmd = 1'b0;
    case (t.req_type)
      REQ_TICK: begin
        if (jt_dir != DIR_BRK) begin
          if (jt_glitches >= joint_cfg.glitch_limit) begin
            hold_still(t.sensor_sample);
            jt_dir      = DIR_BRK;
            jt_fault    = 1'b1;
            jt_glitches = '0;
          end else begin
            jump = (jt_last_good > t.sensor_sample) ? jt_last_good - t.sensor_sample
                                                    : t.sensor_sample - jt_last_good;
            if (jump >= joint_cfg.glitch_jump) begin
              if (jt_glitches != '1) jt_glitches = jt_glitches + GLITCH_BITS'(1);
            end else begin
              jt_dist = (jt_target > t.sensor_sample) ? jt_target - t.sensor_sample
                                                      : t.sensor_sample - jt_target;
              if (t.sensor_sample < joint_cfg.min_position) begin
                steer(DIR_FWD);
              end else if (t.sensor_sample > joint_cfg.max_position) begin
                steer(DIR_BWD);
              end else if (jt_dist < joint_cfg.deadband) begin
                steer(DIR_REL);
                jt_done = 1'b1;
              end else if (t.sensor_sample < jt_target) begin
                steer(DIR_FWD);
              end else if (t.sensor_sample > jt_target) begin
                steer(DIR_BWD);
              end
              jt_last_good = t.sensor_sample;
            end
          end
        end
      end
      REQ_MOVE_TO: head_for(t.goal_position);
      REQ_MOVE_DIR: begin
        if (t.move_backward) begin
          jt_target = joint_cfg.min_position;
          steer(DIR_BWD);
        end else begin
          jt_target = joint_cfg.max_position;
          steer(DIR_FWD);
        end
        jt_done = 1'b0;
      end
      REQ_RELEASE: hold_still(t.sensor_sample);
      REQ_BRAKE: begin
        hold_still(t.sensor_sample);
        jt_dir = DIR_BRK;
      end
      REQ_PARK: head_for(joint_cfg.park_position);
      default: ;
    endcase
    res.drive_dir     = jt_dir;
    res.drive_changed = jt_run_cmd;
    res.move_done     = jt_done;
    res.fault_code    = jt_fault;
    res.target_out    = jt_target;
    res.distance_out  = jt_dist;
    return res;
  endfunction

  function automatic void check_field(string name, logic [SAMPLE_BITS-1:0] want_v,
                                      logic [SAMPLE_BITS-1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endfunction

  task automatic write_reg(cfg_idx_e idx, pos_t value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_MIN_POS:    joint_cfg.min_position  = value;
      CFG_MAX_POS:    joint_cfg.max_position  = value;
      CFG_PARK_POS:   joint_cfg.park_position = value;
      CFG_GLITCH_LIM: joint_cfg.glitch_limit  = value[GLITCH_BITS-1:0];
      CFG_GLITCH_JMP: joint_cfg.glitch_jump   = value;
      CFG_DEADBAND:   joint_cfg.deadband      = value;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Offer one transaction, predict it once accepted
  task automatic send_item(in_t t, logic fixed, out_t want);
    out_t got;
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_data_i  <= t;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    got = step_joint(t);
    pending_results.push_back(fixed ? want : got);
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no transaction pending: %p", out_data_o);
        mismatches++;
      end else begin
        oldest = pending_results.pop_front();
        check_field("drive_dir", SAMPLE_BITS'(oldest.drive_dir),
                    SAMPLE_BITS'(out_data_o.drive_dir));
        check_field("drive_changed", SAMPLE_BITS'(oldest.drive_changed),
                    SAMPLE_BITS'(out_data_o.drive_changed));
        check_field("move_done", SAMPLE_BITS'(oldest.move_done),
                    SAMPLE_BITS'(out_data_o.move_done));
        check_field("fault_code", SAMPLE_BITS'(oldest.fault_code),
                    SAMPLE_BITS'(out_data_o.fault_code));
        check_field("target_out", oldest.target_out, out_data_o.target_out);
        check_field("distance_out", oldest.distance_out, out_data_o.distance_out);
      end
    end
  end

  // Receiver stalls; a hold request forces a long hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_seq != hold_seen) begin
      hold_seen   <= hold_seq;
      hold_left   <= HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Watchdog: end the run once nothing moves for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    in_t  t;
    cfg_t setup;
    int   sim_pos;
    int   r;
    int   step;

    joint_cfg    = '{MinPosRst, MaxPosRst, ParkPosRst, GlitchLimRst, GlitchJmpRst, DeadbandRst};
    jt_target    = MinPosRst;
    jt_last_good = MinPosRst;
    jt_dir       = DIR_BRK;
    jt_glitches  = '0;
    jt_done      = 1'b1;
    jt_fault     = 1'b0;
    jt_dist      = '0;
    jt_run_cmd   = 1'b0;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) send_item(plan[i].stim, plan[i].fixed, plan[i].want);

    sim_pos = int'(jt_last_good);
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      settle();
      case (phase)
        0: setup = '{10'd0, 10'd1023, 10'd1023, 4'd15, 10'd1023, 10'd0};
        1: setup = '{10'd100, 10'd900, 10'd50, 4'd1, 10'd1, 10'd1023};
        // crossed limits
        2: setup = '{10'd600, 10'd300, 10'd450, 4'd3, 10'd200, 10'd5};
        3: setup = '{10'd1023, 10'd1023, 10'd0, 4'd8, 10'd64, 10'd0};
        default: begin
          setup.min_position  = pos_t'($urandom_range(0, 400));
          setup.max_position  = pos_t'($urandom_range(600, 1023));
          setup.park_position = pos_t'($urandom_range(0, 1023));
          setup.glitch_limit  = glitch_t'($urandom_range(1, 15));
          setup.glitch_jump   = pos_t'($urandom_range(16, 300));
          setup.deadband      = pos_t'($urandom_range(0, 30));
        end
      endcase
      write_reg(CFG_MIN_POS, setup.min_position);
      write_reg(CFG_MAX_POS, setup.max_position);
      write_reg(CFG_PARK_POS, setup.park_position);
      write_reg(CFG_GLITCH_LIM, pos_t'(setup.glitch_limit));
      write_reg(CFG_GLITCH_JMP, setup.glitch_jump);
      write_reg(CFG_DEADBAND, setup.deadband);
      cfg_valid_i <= 1'b0;
      quiet = (phase == QUIET_PHASE);

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == HOLD_PHASE && n == 30) hold_seq++;
        r = $urandom_range(0, 99);
        t.sensor_sample = pos_t'($urandom_range(0, 1023));
        t.goal_position = pos_t'($urandom_range(0, 1023));
        t.move_backward = 1'($urandom_range(0, 1));
        if (r < 65) begin
          // advance the joint along its drive direction, drift when idle
          step = $urandom_range(0, 24);
          if (jt_dir == DIR_FWD) sim_pos += step;
          else if (jt_dir == DIR_BWD) sim_pos -= step;
          else sim_pos += int'($urandom_range(0, 4)) - 2;
          if (sim_pos < 0) sim_pos = 0;
          if (sim_pos > 1023) sim_pos = 1023;
          if ($urandom_range(0, 2) == 0 && sim_pos - int'(jt_target) <= 24 &&
              int'(jt_target) - sim_pos <= 24)
            sim_pos = int'(jt_target);
          t.req_type      = REQ_TICK;
          t.sensor_sample = pos_t'(sim_pos);
        end else if (r < 72) begin
          t.req_type = REQ_TICK;
        end else if (r < 97) begin
          t.req_type = REQ_BITS'($urandom_range(REQ_MOVE_TO, REQ_PARK));
        end else begin
          t.req_type = REQ_BITS'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
        end
        send_item(t, 1'b0, NO_WANT);
      end
    end

    settle();
    if (mismatches == 0 && pending_results.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
